>>> hdl/cse_pkg.sv
`timescale 1ns / 1ps

package cse_pkg;

    localparam int OP_W     = 2;
    localparam int ID_W     = 4;
    localparam int PID_W    = 5;
    localparam int PASS_W   = 8;
    localparam int STATUS_W = 2;

    // Pass count saturates here
    localparam logic [PASS_W-1:0] PASS_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_WAIT  = 2'd1,
        OP_POST  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_NO_SEM  = 2'd2,
        ST_Q_FULL  = 2'd3
    } t_status;

endpackage

>>> hdl/counting_semaphore_engine_unit.sv
`timescale 1ns / 1ps

// Counting semaphore engine: allocate, wait and post on a bank of semaphores, each with a
// pass count and a FIFO wait queue of process ids. One transaction is taken per cycle while
// the result side is not stalled. It sits in the input register, then a single
// read-modify-write of the semaphore tables loads the result register. Pass counts and
// queue pointers sit in flops; the queued process ids sit in a single-port-write,
// single-port-read memory whose registered read supplies the released id. Only the first
// sixteen semaphores are addressable, so at most sixteen have table entries. A stalled
// result holds while the input side keeps moving as long as the input register is free.
module counting_semaphore_engine_unit
    import cse_pkg::*;
#(
    parameter int NUM_SEMAPHORES = 16,
    parameter int WAIT_DEPTH     = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [ID_W-1:0]     i_sem_id,
    input  logic [PID_W-1:0]    i_pid,
    input  logic [PASS_W-1:0]   i_init_passes,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_granted_id,
    output logic                o_released_valid,
    output logic [PID_W-1:0]    o_released_pid,
    output logic [PASS_W-1:0]   o_pass_count
);

    localparam int ADDR_SEMS = 1 << ID_W;
    localparam int SEM_STORE = (NUM_SEMAPHORES < ADDR_SEMS) ? NUM_SEMAPHORES : ADDR_SEMS;
    localparam int SW        = $clog2(SEM_STORE);
    localparam int PW        = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW        = $clog2(WAIT_DEPTH + 1);
    localparam int NW        = $clog2(NUM_SEMAPHORES + 1);
    localparam int AW        = SW + PW;
    localparam int MEM_DEPTH = SEM_STORE * (1 << PW);

    localparam logic [PW-1:0] PTR_LAST  = PW'(WAIT_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(WAIT_DEPTH);
    localparam logic [NW-1:0] NU_LIMIT  = NW'(NUM_SEMAPHORES);
    localparam logic [NW-1:0] STORE_LIM = NW'(SEM_STORE);

    // Input register
    logic               r_in_vld;
    t_op                r_op;
    logic [ID_W-1:0]    r_sem_id;
    logic [PID_W-1:0]   r_pid;
    logic [PASS_W-1:0]  r_init;

    // Semaphore tables
    logic [NW-1:0]      r_next_unused;
    logic [PASS_W-1:0]  r_passes [SEM_STORE];
    logic [PW-1:0]      r_head   [SEM_STORE];
    logic [PW-1:0]      r_tail   [SEM_STORE];
    logic [CW-1:0]      r_qcount [SEM_STORE];
    logic [PID_W-1:0]   r_waiter_mem [MEM_DEPTH];

    // Result register
    logic               r_out_vld;
    t_status            r_status;
    logic [ID_W-1:0]    r_gid;
    logic               r_rel_vld;
    logic [PID_W-1:0]   r_rd_pid;
    logic [PASS_W-1:0]  r_cnt;

    logic               out_free;
    logic               s1_fire;
    logic               in_fire;

    t_status            n_status;
    logic [ID_W-1:0]    n_gid;
    logic               n_rel_vld;
    logic [PASS_W-1:0]  n_cnt;

    logic               sem_in_range;
    logic [SW-1:0]      sid;
    logic [SW-1:0]      alloc_idx;
    logic [PASS_W-1:0]  cur_pass;
    logic [PW-1:0]      cur_head;
    logic [PW-1:0]      cur_tail;
    logic [CW-1:0]      cur_qcnt;

    logic               alloc_we;
    logic               alloc_tbl_we;
    logic               pass_we;
    logic [PASS_W-1:0]  pass_wdata;
    logic               push;
    logic               pop;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_fire    = r_in_vld && out_free;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_vld && !s1_fire;

    assign sem_in_range = ({{(32-ID_W){1'b0}}, r_sem_id} < 32'(NUM_SEMAPHORES));
    assign sid          = r_sem_id[SW-1:0];
    assign alloc_idx    = r_next_unused[SW-1:0];
    assign cur_pass     = r_passes[sid];
    assign cur_head     = r_head[sid];
    assign cur_tail     = r_tail[sid];
    assign cur_qcnt     = r_qcount[sid];

    always_comb begin
        n_status   = ST_DONE;
        n_gid      = '0;
        n_rel_vld  = 1'b0;
        n_cnt      = '0;
        alloc_we   = 1'b0;
        pass_we    = 1'b0;
        pass_wdata = cur_pass;
        push       = 1'b0;
        pop        = 1'b0;
        unique case (r_op)
            OP_ALLOC: begin
                if (r_next_unused >= NU_LIMIT) begin
                    n_status = ST_NO_SEM;
                end else begin
                    n_gid    = ID_W'(r_next_unused);
                    n_cnt    = r_init;
                    alloc_we = 1'b1;
                end
            end
            OP_WAIT: begin
                if (!sem_in_range) begin
                    n_status = ST_NO_SEM;
                end else if (cur_pass != '0) begin
                    pass_we    = 1'b1;
                    pass_wdata = cur_pass - 1'b1;
                    n_cnt      = cur_pass - 1'b1;
                end else if (cur_qcnt >= CNT_FULL) begin
                    n_status = ST_Q_FULL;
                    n_cnt    = cur_pass;
                end else begin
                    n_status = ST_BLOCKED;
                    n_cnt    = cur_pass;
                    push     = 1'b1;
                end
            end
            OP_POST: begin
                if (!sem_in_range) begin
                    n_status = ST_NO_SEM;
                end else if (cur_qcnt == '0) begin
                    pass_we    = 1'b1;
                    pass_wdata = (cur_pass == PASS_MAX) ? PASS_MAX : cur_pass + 1'b1;
                    n_cnt      = pass_wdata;
                end else begin
                    n_rel_vld = 1'b1;
                    n_cnt     = cur_pass;
                    pop       = 1'b1;
                end
            end
            default: begin
                // unused code: all-zero result, state untouched
                n_status = ST_DONE;
            end
        endcase
    end

    // Semaphores beyond the addressable range get no table entry
    assign alloc_tbl_we = alloc_we && (r_next_unused < STORE_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= t_op'(i_operation);
            r_sem_id <= i_sem_id;
            r_pid    <= i_pid;
            r_init   <= i_init_passes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_unused <= '0;
            for (int k = 0; k < SEM_STORE; k++) begin
                r_passes[k] <= '0;
                r_head[k]   <= '0;
                r_tail[k]   <= '0;
                r_qcount[k] <= '0;
            end
        end else if (s1_fire) begin
            if (alloc_we) begin
                r_next_unused <= r_next_unused + 1'b1;
            end
            if (alloc_tbl_we) begin
                r_passes[alloc_idx] <= r_init;
                r_head[alloc_idx]   <= '0;
                r_tail[alloc_idx]   <= '0;
                r_qcount[alloc_idx] <= '0;
            end
            if (pass_we) begin
                r_passes[sid] <= pass_wdata;
            end
            if (push) begin
                r_tail[sid]   <= (cur_tail == PTR_LAST) ? '0 : cur_tail + 1'b1;
                r_qcount[sid] <= cur_qcnt + 1'b1;
            end
            if (pop) begin
                r_head[sid]   <= (cur_head == PTR_LAST) ? '0 : cur_head + 1'b1;
                r_qcount[sid] <= cur_qcnt - 1'b1;
            end
        end
    end

    // Wait queue storage: one write or one read per transaction
    always_ff @(posedge i_clk) begin
        if (s1_fire && push) begin
            r_waiter_mem[AW'({sid, cur_tail})] <= r_pid;
        end
        if (s1_fire && pop) begin
            r_rd_pid <= r_waiter_mem[AW'({sid, cur_head})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_status  <= n_status;
            r_gid     <= n_gid;
            r_rel_vld <= n_rel_vld;
            r_cnt     <= n_cnt;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_status;
    assign o_granted_id     = r_gid;
    assign o_released_valid = r_rel_vld;
    assign o_released_pid   = r_rel_vld ? r_rd_pid : '0;
    assign o_pass_count     = r_cnt;

endmodule

>>> hdl/cse_checker.sv
`timescale 1ns / 1ps

module cse_checker
    import cse_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [ID_W-1:0]     o_granted_id,
    input logic                o_released_valid,
    input logic [PID_W-1:0]    o_released_pid,
    input logic [PASS_W-1:0]   o_pass_count
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_released_pid) && $stable(o_pass_count))
        else $error("result changed while stalled");

    // A release only comes from a successful post
    a_release_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_released_valid |-> o_status == ST_DONE && o_granted_id == '0)
        else $error("release with non-done status");

    a_release_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_released_valid |-> o_released_pid == '0)
        else $error("released pid without release");

    a_no_sem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NO_SEM |->
            o_pass_count == '0 && o_granted_id == '0 && !o_released_valid)
        else $error("missing semaphore result not cleared");

    // Callers only block or overflow the queue when no pass is left
    a_block_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_BLOCKED || o_status == ST_Q_FULL) |->
            o_pass_count == '0)
        else $error("blocked with passes left");

endmodule

bind counting_semaphore_engine_unit cse_checker u_cse_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_granted_id     (o_granted_id),
    .o_released_valid (o_released_valid),
    .o_released_pid   (o_released_pid),
    .o_pass_count     (o_pass_count)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cse_pkg::*;

    localparam int SEM_COUNT   = 16;
    localparam int QUEUE_DEPTH = 32;
    localparam int ITEM_TARGET = 1400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int FIFO_LIMIT  = 64;

    typedef struct {
        t_op                op;
        logic [ID_W-1:0]    sem;
        logic [PID_W-1:0]   pid;
        logic [PASS_W-1:0]  init;
    } sem_req_t;

    typedef struct {
        t_status            status;
        logic [ID_W-1:0]    gid;
        logic               rel_valid;
        logic [PID_W-1:0]   rel_pid;
        logic [PASS_W-1:0]  count;
    } sem_rsp_t;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic [OP_W-1:0]     i_operation      = '0;
    logic [ID_W-1:0]     i_sem_id         = '0;
    logic [PID_W-1:0]    i_pid            = '0;
    logic [PASS_W-1:0]   i_init_passes    = '0;
    logic                i_out_stall      = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_granted_id;
    logic                o_released_valid;
    logic [PID_W-1:0]    o_released_pid;
    logic [PASS_W-1:0]   o_pass_count;

    counting_semaphore_engine_unit #(
        .NUM_SEMAPHORES(SEM_COUNT),
        .WAIT_DEPTH    (QUEUE_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_sem_id        (i_sem_id),
        .i_pid           (i_pid),
        .i_init_passes   (i_init_passes),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_granted_id    (o_granted_id),
        .o_released_valid(o_released_valid),
        .o_released_pid  (o_released_pid),
        .o_pass_count    (o_pass_count)
    );

    always #2 i_clk = ~i_clk;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    // Predicted state of the semaphore bank
    int             next_free;
    int             sem_passes [SEM_COUNT];
    logic [PID_W-1:0] waiters  [SEM_COUNT][QUEUE_DEPTH];
    int             q_head     [SEM_COUNT];
    int             q_tail     [SEM_COUNT];
    int             q_len      [SEM_COUNT];

    sem_req_t pending_reqs[$];
    sem_rsp_t expected_rsps[$];
    int       n_pushed  = 0;
    int       n_taken   = 0;
    int       n_results = 0;
    int       n_errors  = 0;

    function automatic sem_rsp_t semaphore_apply(input sem_req_t rq);
        sem_rsp_t r;
        int       s;
        r.status    = ST_DONE;
        r.gid       = '0;
        r.rel_valid = 1'b0;
        r.rel_pid   = '0;
        r.count     = '0;
        s           = rq.sem;
        case (rq.op)
            OP_ALLOC: begin
                if (next_free >= SEM_COUNT) begin
                    r.status = ST_NO_SEM;
                end else begin
                    r.gid             = next_free[ID_W-1:0];
                    r.count           = rq.init;
                    sem_passes[next_free] = rq.init;
                    q_head[next_free] = 0;
                    q_tail[next_free] = 0;
                    q_len[next_free]  = 0;
                    next_free++;
                end
            end
            OP_WAIT: begin
                if (s >= SEM_COUNT) begin
                    r.status = ST_NO_SEM;
                end else if (sem_passes[s] > 0) begin
                    sem_passes[s]--;
                    r.count = sem_passes[s][PASS_W-1:0];
                end else if (q_len[s] >= QUEUE_DEPTH) begin
                    r.status = ST_Q_FULL;
                    r.count  = sem_passes[s][PASS_W-1:0];
                end else begin
                    waiters[s][q_tail[s]] = rq.pid;
                    q_tail[s] = (q_tail[s] + 1) % QUEUE_DEPTH;
                    q_len[s]++;
                    r.status = ST_BLOCKED;
                    r.count  = sem_passes[s][PASS_W-1:0];
                end
            end
            OP_POST: begin
                if (s >= SEM_COUNT) begin
                    r.status = ST_NO_SEM;
                end else if (q_len[s] == 0) begin
                    if (sem_passes[s] < PASS_MAX) sem_passes[s]++;
                    r.count = sem_passes[s][PASS_W-1:0];
                end else begin
                    r.rel_valid = 1'b1;
                    r.rel_pid   = waiters[s][q_head[s]];
                    q_head[s]   = (q_head[s] + 1) % QUEUE_DEPTH;
                    q_len[s]--;
                    r.count     = sem_passes[s][PASS_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sender: present queued transactions with a random gap after each
    sem_req_t cur_req;
    int       send_gap  = 0;
    bit       send_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (in_fire) begin
                expected_rsps.push_back(semaphore_apply(cur_req));
                n_taken <= n_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req       = pending_reqs.pop_front();
                    i_operation   <= cur_req.op;
                    i_sem_id      <= cur_req.sem;
                    i_pid         <= cur_req.pid;
                    i_init_passes <= cur_req.init;
                    i_in_valid    <= 1'b1;
                    if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
                    send_gap <= send_calm ? 0 : $urandom_range(0, 8);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result against the oldest prediction, then draw a stall
    int recv_hold = 0;
    bit recv_calm = 1'b0;

    always @(posedge i_clk) begin
        sem_rsp_t exp_r;
        int       n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_hold   <= 0;
        end else begin
            n = recv_hold;
            if (out_fire) begin
                n_results <= n_results + 1;
                if (expected_rsps.size() == 0) begin
                    $error("result with no prediction waiting");
                    n_errors++;
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, o_status);
                        n_errors++;
                    end
                    if (o_granted_id !== exp_r.gid) begin
                        $error("granted_id: expected %0d, got %0d", exp_r.gid, o_granted_id);
                        n_errors++;
                    end
                    if (o_released_valid !== exp_r.rel_valid) begin
                        $error("released_valid: expected %0d, got %0d",
                               exp_r.rel_valid, o_released_valid);
                        n_errors++;
                    end
                    if (o_released_pid !== exp_r.rel_pid) begin
                        $error("released_pid: expected %0d, got %0d",
                               exp_r.rel_pid, o_released_pid);
                        n_errors++;
                    end
                    if (o_pass_count !== exp_r.count) begin
                        $error("pass_count: expected %0d, got %0d", exp_r.count, o_pass_count);
                        n_errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
                // Hold off for a long stretch so the block backs up into its input
                if (n_results == 250 || n_results == 900)
                    n = 150;
                else
                    n = recv_calm ? 0 : $urandom_range(0, 8);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                recv_hold   <= n - 1;
            end else begin
                i_out_stall <= 1'b0;
                recv_hold   <= 0;
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (in_fire || out_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(input t_op op, input int s, input int p, input int ini);
        sem_req_t r;
        while (pending_reqs.size() >= FIFO_LIMIT) @(negedge i_clk);
        r.op   = op;
        r.sem  = s[ID_W-1:0];
        r.pid  = p[PID_W-1:0];
        r.init = ini[PASS_W-1:0];
        pending_reqs.push_back(r);
        n_pushed++;
    endtask

    task automatic settle();
        while (n_taken != n_pushed) @(negedge i_clk);
    endtask

    initial begin
        int kind;
        int s;
        int cnt;
        bit first_drill;
        next_free = 0;
        for (int k = 0; k < SEM_COUNT; k++) begin
            sem_passes[k] = 0;
            q_head[k]     = 0;
            q_tail[k]     = 0;
            q_len[k]      = 0;
        end

        // Directed: count extremes, saturation, FIFO release order, unallocated ids, unused code
        push_req(OP_ALLOC, 0, 0, 0);
        push_req(OP_ALLOC, 15, 31, 255);
        push_req(OP_ALLOC, 0, 0, 1);
        push_req(OP_POST, 1, 0, 0);
        push_req(OP_WAIT, 1, 0, 0);
        push_req(OP_WAIT, 0, 31, 0);
        push_req(OP_WAIT, 0, 0, 255);
        push_req(OP_WAIT, 0, 21, 0);
        push_req(OP_POST, 0, 0, 0);
        push_req(OP_POST, 0, 0, 0);
        push_req(OP_POST, 0, 0, 0);
        push_req(OP_POST, 0, 0, 0);
        push_req(OP_WAIT, 0, 3, 0);
        push_req(OP_WAIT, 15, 10, 0);
        push_req(OP_POST, 15, 0, 0);
        push_req(OP_POST, 15, 0, 0);
        push_req(OP_NONE, 15, 31, 255);
        push_req(OP_NONE, 0, 0, 0);
        push_req(OP_WAIT, 2, 7, 0);
        push_req(OP_WAIT, 2, 7, 0);
        push_req(OP_POST, 2, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        first_drill = 1'b1;
        while (n_pushed < ITEM_TARGET) begin
            kind = first_drill ? 0 : $urandom_range(0, 99);
            first_drill = 1'b0;
            if (kind < 15) begin
                // Drain the emptiest semaphore, try to overfill its wait queue, then release some
                settle();
                s = 0;
                for (int k = 1; k < SEM_COUNT; k++)
                    if (sem_passes[k] < sem_passes[s]) s = k;
                cnt = sem_passes[s] + QUEUE_DEPTH - q_len[s] + $urandom_range(1, 3);
                if (cnt > 90) cnt = 90;
                repeat (cnt) push_req(OP_WAIT, s, $urandom_range(0, 31), $urandom_range(0, 255));
                repeat ($urandom_range(0, 40))
                    push_req(OP_POST, s, $urandom_range(0, 31), $urandom_range(0, 255));
            end else if (kind < 25) begin
                // Post to the fullest semaphore, pushing it into saturation when it is near the limit
                settle();
                s = 0;
                for (int k = 1; k < SEM_COUNT; k++)
                    if (sem_passes[k] > sem_passes[s]) s = k;
                cnt = PASS_MAX - sem_passes[s] + q_len[s] + $urandom_range(1, 3);
                if (cnt > 60) cnt = 40;
                repeat (cnt) push_req(OP_POST, s, $urandom_range(0, 31), $urandom_range(0, 255));
            end else if (kind < 65) begin
                s = $urandom_range(0, SEM_COUNT - 1);
                repeat ($urandom_range(4, 24))
                    push_req($urandom_range(0, 1) ? OP_WAIT : OP_POST, s,
                             $urandom_range(0, 31), $urandom_range(0, 255));
            end else if (kind < 75) begin
                push_req(OP_ALLOC, $urandom_range(0, 15), $urandom_range(0, 31),
                         $urandom_range(0, 255));
            end else begin
                repeat ($urandom_range(1, 6))
                    push_req(t_op'($urandom_range(0, 3)), $urandom_range(0, 15),
                             $urandom_range(0, 31), $urandom_range(0, 255));
            end
        end

        // Exhaust the bank and ask for more
        repeat (SEM_COUNT + 2)
            push_req(OP_ALLOC, $urandom_range(0, 15), $urandom_range(0, 31),
                     $urandom_range(0, 255));

        settle();
        while (expected_rsps.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (n_errors == 0 && expected_rsps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cse_pkg.sv
hdl/counting_semaphore_engine_unit.sv
hdl/cse_checker.sv
tb/sv/tb_top.sv
